>>> hw/rtl/hsvrgb_pkg.sv
// Shared types and constants of the HSV to RGB converter.
`default_nettype none

package hsvrgb_pkg;

  localparam int HueW  = 12;
  localparam int PctW  = 7;
  localparam int ChanW = 8;
  localparam int SvW   = 14;  // product of two percentages, up to 10000
  localparam int XfW   = 9;   // position inside a sector, 0..480
  localparam int NumW  = 23;  // channel numerator over 4800000

  localparam int HueMax        = 2880;
  localparam int PctMax        = 100;
  localparam int SectorEighths = 480;

  // n*255 + Half fits in 31 bits; divide by 4800000 = 512 * 9375
  localparam int ScaledW    = 31;
  localparam int ChanMul    = 255;
  localparam int Half       = 2400000;
  localparam int DivShift   = 9;
  localparam int DivOdd     = 9375;
  localparam int ShiftedW   = ScaledW - DivShift;
  localparam int RecipMul   = 458129;  // floor(2^32 / 9375)
  localparam int RecipShift = 32;
  localparam int RecipW     = 19;
  localparam int ProdW      = ShiftedW + RecipW;

  typedef struct packed {
    logic valid;
    logic err;
  } stage_ctl_t;

  // channel order: red, green, blue
  typedef logic [2:0][NumW-1:0]  num_arr_t;
  typedef logic [2:0][ChanW-1:0] chan_arr_t;

endpackage

`default_nettype wire

>>> hw/rtl/hsvrgb_mix.sv
// Front stages: range check, sector split, chroma and per-channel numerators.
`default_nettype none

module hsvrgb_mix (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic [hsvrgb_pkg::HueW-1:0]   hue_i,
  input  wire logic [hsvrgb_pkg::PctW-1:0]   saturation_i,
  input  wire logic [hsvrgb_pkg::PctW-1:0]   brightness_i,
  output hsvrgb_pkg::stage_ctl_t             ctl_o,
  output hsvrgb_pkg::num_arr_t               num_o
);

  localparam int HueW = hsvrgb_pkg::HueW;
  localparam int PctW = hsvrgb_pkg::PctW;
  localparam int SvW  = hsvrgb_pkg::SvW;
  localparam int XfW  = hsvrgb_pkg::XfW;
  localparam int NumW = hsvrgb_pkg::NumW;
  localparam int Sec  = hsvrgb_pkg::SectorEighths;

  // ---------------- stage 1 ----------------
  hsvrgb_pkg::stage_ctl_t s1_ctl_d, s1_ctl_q;
  logic [2:0]      sector_d, sector_q;
  logic [XfW-1:0]  xf_d, xf_q;
  logic [SvW-1:0]  sv_d, sv_q;
  logic [SvW-1:0]  mv_d, mv_q;
  logic [HueW-1:0] base;
  logic [HueW-1:0] offset;

  always_comb begin
    s1_ctl_d.valid = in_valid_i;
    s1_ctl_d.err   = (hue_i > HueW'(hsvrgb_pkg::HueMax))
                  || (saturation_i > PctW'(hsvrgb_pkg::PctMax))
                  || (brightness_i > PctW'(hsvrgb_pkg::PctMax));

    priority if (hue_i >= HueW'(6 * Sec)) begin
      sector_d = 3'd6; base = HueW'(6 * Sec);
    end else if (hue_i >= HueW'(5 * Sec)) begin
      sector_d = 3'd5; base = HueW'(5 * Sec);
    end else if (hue_i >= HueW'(4 * Sec)) begin
      sector_d = 3'd4; base = HueW'(4 * Sec);
    end else if (hue_i >= HueW'(3 * Sec)) begin
      sector_d = 3'd3; base = HueW'(3 * Sec);
    end else if (hue_i >= HueW'(2 * Sec)) begin
      sector_d = 3'd2; base = HueW'(2 * Sec);
    end else if (hue_i >= HueW'(Sec)) begin
      sector_d = 3'd1; base = HueW'(Sec);
    end else begin
      sector_d = 3'd0; base = '0;
    end

    offset = hue_i - base;
    // X rises through even sectors and falls through odd ones
    xf_d = sector_d[0] ? (XfW'(Sec) - offset[XfW-1:0]) : offset[XfW-1:0];
    sv_d = SvW'(saturation_i) * SvW'(brightness_i);
    mv_d = SvW'(PctW'(hsvrgb_pkg::PctMax) - saturation_i)
         * SvW'(brightness_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
    end else begin
      s1_ctl_q <= s1_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sector_q <= sector_d;
    xf_q     <= xf_d;
    sv_q     <= sv_d;
    mv_q     <= mv_d;
  end

  // ---------------- stage 2 ----------------
  hsvrgb_pkg::stage_ctl_t s2_ctl_q;
  hsvrgb_pkg::num_arr_t   num_d, num_q;
  logic [NumW-1:0] cn, xn, mn, cm, xm;

  always_comb begin
    cn = NumW'(sv_q) * NumW'(Sec);
    mn = NumW'(mv_q) * NumW'(Sec);
    xn = NumW'(sv_q) * NumW'(xf_q);
    cm = cn + mn;
    xm = xn + mn;
    unique case (sector_q)
      3'd0:    num_d = {mn, xm, cm};
      3'd1:    num_d = {mn, cm, xm};
      3'd2:    num_d = {xm, cm, mn};
      3'd3:    num_d = {cm, xm, mn};
      3'd4:    num_d = {cm, mn, xm};
      default: num_d = {xm, mn, cm};
    endcase
    // zero numerators scale to zero colour
    if (s1_ctl_q.err) begin
      num_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q <= '0;
    end else begin
      s2_ctl_q <= s1_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
  end

  assign ctl_o = s2_ctl_q;
  assign num_o = num_q;

  xf_in_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_ctl_q.valid && !s1_ctl_q.err) |-> (xf_q <= XfW'(Sec)))
    else $error("sector position out of range");

  err_zeroes_num: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_ctl_q.valid && s1_ctl_q.err) |=> (num_q == '0))
    else $error("range error did not clear numerators");

endmodule

`default_nettype wire

>>> hw/rtl/hsvrgb_scale.sv
// Back stages: scale each numerator to 0..255 with round-half-up, three lanes.
`default_nettype none

module hsvrgb_scale (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire hsvrgb_pkg::stage_ctl_t ctl_i,
  input  wire hsvrgb_pkg::num_arr_t   num_i,
  output hsvrgb_pkg::stage_ctl_t      ctl_o,
  output hsvrgb_pkg::chan_arr_t       chan_o
);

  localparam int ChanW    = hsvrgb_pkg::ChanW;
  localparam int ScaledW  = hsvrgb_pkg::ScaledW;
  localparam int ShiftedW = hsvrgb_pkg::ShiftedW;
  localparam int ProdW    = hsvrgb_pkg::ProdW;
  localparam int RShift   = hsvrgb_pkg::RecipShift;

  hsvrgb_pkg::stage_ctl_t s3_ctl_q, s4_ctl_q;
  logic [2:0][ShiftedW-1:0] x_q;
  logic [2:0][ChanW-1:0]    q0_q;
  logic [2:0][ShiftedW-1:0] rem;
  hsvrgb_pkg::chan_arr_t    chan_d, chan_q;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [ScaledW-1:0]  y;
    logic [ShiftedW-1:0] x_d;
    logic [ProdW-1:0]    prod;

    // stage 3: quotient estimate by reciprocal, low by at most one
    always_comb begin
      y    = ScaledW'(num_i[l]) * ScaledW'(hsvrgb_pkg::ChanMul)
           + ScaledW'(hsvrgb_pkg::Half);
      x_d  = y[ScaledW-1:hsvrgb_pkg::DivShift];
      prod = ProdW'(x_d) * ProdW'(hsvrgb_pkg::RecipMul);
    end

    always_ff @(posedge clk_i) begin
      x_q[l]  <= x_d;
      q0_q[l] <= prod[RShift+ChanW-1:RShift];
    end

    // stage 4: one correction step
    always_comb begin
      rem[l] = x_q[l] - ShiftedW'(q0_q[l]) * ShiftedW'(hsvrgb_pkg::DivOdd);
      chan_d[l] = q0_q[l]
                + ChanW'(rem[l] >= ShiftedW'(hsvrgb_pkg::DivOdd));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_ctl_q <= '0;
      s4_ctl_q <= '0;
    end else begin
      s3_ctl_q <= ctl_i;
      s4_ctl_q <= s3_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    chan_q <= chan_d;
  end

  assign ctl_o  = s4_ctl_q;
  assign chan_o = chan_q;

  estimate_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_ctl_q.valid |-> (rem[0] < ShiftedW'(2 * hsvrgb_pkg::DivOdd))
                    && (rem[1] < ShiftedW'(2 * hsvrgb_pkg::DivOdd))
                    && (rem[2] < ShiftedW'(2 * hsvrgb_pkg::DivOdd)))
    else $error("reciprocal estimate off by more than one");

  err_gives_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_ctl_q.valid && s4_ctl_q.err) |-> (chan_q == '0))
    else $error("range error with nonzero colour");

endmodule

`default_nettype wire

>>> hw/rtl/hsv_to_rgb_converter_top.sv
// HSV to RGB converter top level: four-stage pipeline, one colour per clock.
//
//  channel  | signals                                   | transfer
//  ---------+-------------------------------------------+------------------------
//  command  | start_i, busy_o, hue_i, saturation_i,     | start_i && !busy_o
//           | brightness_i                              |
//  result   | done_o, red_o, green_o, blue_o,           | done_o, one cycle
//           | range_error_o                             |
//
// A command reaches done_o through the stages below; one command per cycle.
// Stages: sector/chroma products, channel numerators, reciprocal estimate, correction.
// busy_o stays low: the pipeline never stalls, since results cannot be held off.
// Reset clears the valid and error bits only; no result appears until a new command.
`default_nettype none

module hsv_to_rgb_converter_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output      logic                        busy_o,
  input  wire logic [hsvrgb_pkg::HueW-1:0] hue_i,
  input  wire logic [hsvrgb_pkg::PctW-1:0] saturation_i,
  input  wire logic [hsvrgb_pkg::PctW-1:0] brightness_i,
  output      logic                        done_o,
  output      logic [hsvrgb_pkg::ChanW-1:0] red_o,
  output      logic [hsvrgb_pkg::ChanW-1:0] green_o,
  output      logic [hsvrgb_pkg::ChanW-1:0] blue_o,
  output      logic                        range_error_o
);

  hsvrgb_pkg::stage_ctl_t mix_ctl, out_ctl;
  hsvrgb_pkg::num_arr_t   mix_num;
  hsvrgb_pkg::chan_arr_t  chan;
  logic                   accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  hsvrgb_mix u_mix (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (accept),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .ctl_o        (mix_ctl),
    .num_o        (mix_num)
  );

  hsvrgb_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mix_ctl),
    .num_i  (mix_num),
    .ctl_o  (out_ctl),
    .chan_o (chan)
  );

  assign done_o        = out_ctl.valid;
  assign range_error_o = out_ctl.err;
  assign red_o         = chan[0];
  assign green_o       = chan[1];
  assign blue_o        = chan[2];

  accept_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##3 done_o)
    else $error("accepted command produced no result");

endmodule

`default_nettype wire
